// ===== sv/assert_macros.svh =====
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: label failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: label failed");

`endif

// ===== sv/drt_pkg.sv =====
package drt_pkg;

  localparam int unsigned CFG_W = 10;
  localparam int unsigned POS_W = 12;
  localparam int unsigned DIM_W = 11;
  localparam int unsigned GAP   = 2;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_MERGE = 2'd1,
    CMD_LIST  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_DONE     = 3'd3,
    ST_RECT     = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_PLAY_X = 2'd0,
    REG_PLAY_Y = 2'd1,
    REG_PLAY_W = 2'd2,
    REG_PLAY_H = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_CLEAR,
    S_LIST,
    S_LOUT,
    S_MSTART,
    S_MLOADA,
    S_MCMP,
    S_MMOVE
  } state_t;

endpackage

// ===== sv/drt_merge_unit.sv =====
module drt_merge_unit #(
  parameter int unsigned CW = 11
) (
  input  logic [4*CW-1:0] rect_a,
  input  logic [4*CW-1:0] rect_b,
  output logic            near,
  output logic [4*CW-1:0] merged
);

  logic [CW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
  logic [CW+1:0] a_r, a_b, b_r, b_b;
  logic [CW-1:0] nx, ny;
  logic [CW+1:0] nx1, ny1;

  assign {ax, ay, aw, ah} = rect_a;
  assign {bx, by, bw, bh} = rect_b;

  // far edges, wide enough to hold the gap allowance
  assign a_r = (CW+2)'(ax) + (CW+2)'(aw);
  assign a_b = (CW+2)'(ay) + (CW+2)'(ah);
  assign b_r = (CW+2)'(bx) + (CW+2)'(bw);
  assign b_b = (CW+2)'(by) + (CW+2)'(bh);

  assign near = ((CW+2)'(ax) <= b_r + (CW+2)'(drt_pkg::GAP)) &&
                ((CW+2)'(bx) <= a_r + (CW+2)'(drt_pkg::GAP)) &&
                ((CW+2)'(ay) <= b_b + (CW+2)'(drt_pkg::GAP)) &&
                ((CW+2)'(by) <= a_b + (CW+2)'(drt_pkg::GAP));

  assign nx  = (ax < bx) ? ax : bx;
  assign ny  = (ay < by) ? ay : by;
  assign nx1 = (a_r > b_r) ? a_r : b_r;
  assign ny1 = (a_b > b_b) ? a_b : b_b;

  assign merged = {nx, ny, CW'(nx1 - (CW+2)'(nx)), CW'(ny1 - (CW+2)'(ny))};

endmodule

// ===== sv/dirty_rect_tracker.sv =====
// Dirty rectangle tracker.
// Command channel: a command beat is taken on a rising edge with start high
// and busy low. Commands: add (clip rect_x/y/w/h to the play area and store;
// drop if empty; a full table keeps only the play area), merge (join near or
// overlapping pairs until none are left), list (emit all stored rects), clear.
// Result channel: each result beat is shown for exactly one cycle with valid
// high; the receiver cannot stall, so nothing here ever waits on it.
// Config port: cfg_we/cfg_addr/cfg_data write play_x, play_y, play_w, play_h;
// write only while busy is low and no result is pending.
// Timing: add and clear pass through one working state that registers their
// beat; the state is back to idle while it is shown, so the next command can
// be taken on the edge that ends it. List reads entry 0 in S_LIST, then gives
// one beat per cycle from S_LOUT, one per stored entry (an empty table gives
// a single empty-status beat). Merge runs a pair scan over the table memory:
// start, a load per left entry, a compare per pair, and per join a move of the
// last entry if needed and a restart, since the table is read once per cycle.
// Reset clears the entry count and config; table contents are not cleared,
// only entries below the count are ever read.
module dirty_rect_tracker #(
  parameter int unsigned MAX_RECTS   = 32,
  parameter int unsigned COORD_WIDTH = 11,
  localparam int unsigned CNT_W = $clog2(MAX_RECTS + 1),
  localparam int unsigned IDX_W = $clog2(MAX_RECTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command,
  input  logic signed [drt_pkg::POS_W-1:0] rect_x,
  input  logic signed [drt_pkg::POS_W-1:0] rect_y,
  input  logic [drt_pkg::DIM_W-1:0]    rect_w,
  input  logic [drt_pkg::DIM_W-1:0]    rect_h,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_addr,
  input  logic [drt_pkg::CFG_W-1:0]    cfg_data,
  output logic                         valid,
  output logic [2:0]                   status,
  output logic [COORD_WIDTH-1:0]       out_x,
  output logic [COORD_WIDTH-1:0]       out_y,
  output logic [COORD_WIDTH-1:0]       out_w,
  output logic [COORD_WIDTH-1:0]       out_h,
  output logic [CNT_W-1:0]             rect_count,
  output logic                         last
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned RW = 4 * CW;
  localparam int unsigned AW = drt_pkg::POS_W + 2;  // signed clip math

  drt_pkg::state_t state, state_next;

  logic [drt_pkg::CFG_W-1:0] play_x, play_y, play_w, play_h;

  // captured command beat
  logic signed [drt_pkg::POS_W-1:0] cap_x, cap_y;
  logic [drt_pkg::DIM_W-1:0] cap_w, cap_h;

  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] i_idx, i_idx_next, j_idx, j_idx_next;
  logic [RW-1:0]    a_rect, a_rect_next;

  // table memory, one read and one write port, registered read
  logic [RW-1:0]    table_mem [MAX_RECTS];
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [RW-1:0]    rd_data, wr_data;

  // result beat being formed
  logic             res_valid, res_last;
  drt_pkg::status_t res_status;
  logic [RW-1:0]    res_rect;

  logic             near;
  logic [RW-1:0]    merged;

  // add clipping
  logic signed [AW-1:0] cx, cy, cx1, cy1, px, py, px1, py1;
  logic signed [AW-1:0] left, top, right, bottom;
  logic                 clip_drop;
  logic [CNT_W-1:0]     j_plus1, i_plus2;

  drt_merge_unit #(.CW(CW)) u_merge (
    .rect_a (a_rect),
    .rect_b (rd_data),
    .near   (near),
    .merged (merged)
  );

  always_comb begin
    cx  = AW'(cap_x);
    cy  = AW'(cap_y);
    cx1 = cx + AW'(cap_w);
    cy1 = cy + AW'(cap_h);
    px  = AW'(play_x);
    py  = AW'(play_y);
    px1 = px + AW'(play_w);
    py1 = py + AW'(play_h);
    left   = (cx > px) ? cx : px;
    top    = (cy > py) ? cy : py;
    right  = (cx1 < px1) ? cx1 : px1;
    bottom = (cy1 < py1) ? cy1 : py1;
    clip_drop = (right <= left) || (bottom <= top);
  end

  assign j_plus1 = CNT_W'(j_idx) + CNT_W'(1);
  assign i_plus2 = CNT_W'(i_idx) + CNT_W'(2);

  assign busy = (state != drt_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= drt_pkg::S_IDLE;
      count  <= '0;
      play_x <= '0;
      play_y <= '0;
      play_w <= '0;
      play_h <= '0;
      valid  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      valid <= res_valid;
      if (cfg_we) begin
        unique case (drt_pkg::reg_idx_t'(cfg_addr))
          drt_pkg::REG_PLAY_X: play_x <= cfg_data;
          drt_pkg::REG_PLAY_Y: play_y <= cfg_data;
          drt_pkg::REG_PLAY_W: play_w <= cfg_data;
          drt_pkg::REG_PLAY_H: play_h <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cap_x <= rect_x;
      cap_y <= rect_y;
      cap_w <= rect_w;
      cap_h <= rect_h;
    end
    i_idx      <= i_idx_next;
    j_idx      <= j_idx_next;
    a_rect     <= a_rect_next;
    status     <= res_status;
    {out_x, out_y, out_w, out_h} <= res_rect;
    rect_count <= count_next;
    last       <= res_last;
  end

  always_ff @(posedge clk) begin
    if (wr_en) table_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= table_mem[rd_addr];
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    i_idx_next  = i_idx;
    j_idx_next  = j_idx;
    a_rect_next = a_rect;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    res_valid   = 1'b0;
    res_status  = drt_pkg::ST_DONE;
    res_rect    = '0;
    res_last    = 1'b0;

    unique case (state)
      drt_pkg::S_IDLE: begin
        if (start) begin
          unique case (drt_pkg::cmd_t'(command))
            drt_pkg::CMD_ADD:   state_next = drt_pkg::S_ADD;
            drt_pkg::CMD_MERGE: state_next = drt_pkg::S_MSTART;
            drt_pkg::CMD_LIST:  state_next = drt_pkg::S_LIST;
            drt_pkg::CMD_CLEAR: state_next = drt_pkg::S_CLEAR;
            default: ;
          endcase
        end
      end

      drt_pkg::S_ADD: begin
        res_valid  = 1'b1;
        res_last   = 1'b1;
        state_next = drt_pkg::S_IDLE;
        if (count >= CNT_W'(MAX_RECTS)) begin
          // full list: collapse to the whole play area
          wr_en      = 1'b1;
          wr_addr    = '0;
          wr_data    = {CW'(play_x), CW'(play_y), CW'(play_w), CW'(play_h)};
          count_next = CNT_W'(1);
          res_status = drt_pkg::ST_OVERFLOW;
        end else if (clip_drop) begin
          res_status = drt_pkg::ST_DROPPED;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = count[IDX_W-1:0];
          wr_data    = {CW'(left), CW'(top), CW'(right - left), CW'(bottom - top)};
          count_next = count + CNT_W'(1);
          res_status = drt_pkg::ST_STORED;
        end
      end

      drt_pkg::S_CLEAR: begin
        count_next = '0;
        res_valid  = 1'b1;
        res_last   = 1'b1;
        state_next = drt_pkg::S_IDLE;
      end

      drt_pkg::S_LIST: begin
        if (count == '0) begin
          res_valid  = 1'b1;
          res_last   = 1'b1;
          res_status = drt_pkg::ST_EMPTY;
          state_next = drt_pkg::S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = '0;
          i_idx_next = '0;
          state_next = drt_pkg::S_LOUT;
        end
      end

      drt_pkg::S_LOUT: begin
        res_valid  = 1'b1;
        res_status = drt_pkg::ST_RECT;
        res_rect   = rd_data;
        res_last   = (CNT_W'(i_idx) + CNT_W'(1) == count);
        if (res_last) begin
          state_next = drt_pkg::S_IDLE;
        end else begin
          i_idx_next = i_idx + IDX_W'(1);
          rd_en      = 1'b1;
          rd_addr    = i_idx + IDX_W'(1);
        end
      end

      drt_pkg::S_MSTART: begin
        if (count <= CNT_W'(1)) begin
          res_valid  = 1'b1;
          res_last   = 1'b1;
          state_next = drt_pkg::S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = '0;
          i_idx_next = '0;
          state_next = drt_pkg::S_MLOADA;
        end
      end

      drt_pkg::S_MLOADA: begin
        a_rect_next = rd_data;
        j_idx_next  = i_idx + IDX_W'(1);
        rd_en       = 1'b1;
        rd_addr     = i_idx + IDX_W'(1);
        state_next  = drt_pkg::S_MCMP;
      end

      drt_pkg::S_MCMP: begin
        if (near) begin
          // join into slot i; last entry fills slot j unless j is last
          wr_en   = 1'b1;
          wr_addr = i_idx;
          wr_data = merged;
          if (j_plus1 < count) begin
            rd_en      = 1'b1;
            rd_addr    = IDX_W'(count - CNT_W'(1));
            state_next = drt_pkg::S_MMOVE;
          end else begin
            count_next = count - CNT_W'(1);
            state_next = drt_pkg::S_MSTART;
          end
        end else if (j_plus1 < count) begin
          j_idx_next = j_idx + IDX_W'(1);
          rd_en      = 1'b1;
          rd_addr    = j_idx + IDX_W'(1);
        end else if (i_plus2 < count) begin
          i_idx_next = i_idx + IDX_W'(1);
          rd_en      = 1'b1;
          rd_addr    = i_idx + IDX_W'(1);
          state_next = drt_pkg::S_MLOADA;
        end else begin
          res_valid  = 1'b1;
          res_last   = 1'b1;
          state_next = drt_pkg::S_IDLE;
        end
      end

      drt_pkg::S_MMOVE: begin
        wr_en      = 1'b1;
        wr_addr    = j_idx;
        wr_data    = rd_data;
        count_next = count - CNT_W'(1);
        state_next = drt_pkg::S_MSTART;
      end

      default: state_next = drt_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== sv/drt_checker.sv =====
`include "assert_macros.svh"

module drt_checker #(
  parameter int unsigned MAX_RECTS   = 32,
  parameter int unsigned COORD_WIDTH = 11,
  localparam int unsigned CNT_W = $clog2(MAX_RECTS + 1)
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   busy,
  input logic                   valid,
  input logic [2:0]             status,
  input logic [COORD_WIDTH-1:0] out_x,
  input logic [COORD_WIDTH-1:0] out_y,
  input logic [COORD_WIDTH-1:0] out_w,
  input logic [COORD_WIDTH-1:0] out_h,
  input logic [CNT_W-1:0]       rect_count,
  input logic                   last
);

  logic not_rect;
  assign not_rect = (status != drt_pkg::ST_RECT);

  // a beat only follows a cycle of work
  `ASSERT_IMPLY(a_beat_after_busy, clk, rst, valid && !$past(rst), $past(busy))
  // single-beat statuses always close the command
  `ASSERT_IMPLY(a_single_last, clk, rst, valid && not_rect, last)
  // non-rectangle beats carry zero coordinates
  `ASSERT_IMPLY(a_zero_fields, clk, rst, valid && not_rect,
                out_x == '0 && out_y == '0 && out_w == '0 && out_h == '0)
  // count never exceeds capacity
  `ASSERT_IMPLY(a_count_cap, clk, rst, valid, rect_count <= CNT_W'(MAX_RECTS))
  // a non-final list beat is followed by another beat
  `ASSERT_NEXT(a_list_runs, clk, rst, valid && !last, valid)

endmodule

bind dirty_rect_tracker drt_checker #(
  .MAX_RECTS   (MAX_RECTS),
  .COORD_WIDTH (COORD_WIDTH)
) u_drt_checker (
  .clk        (clk),
  .rst        (rst),
  .busy       (busy),
  .valid      (valid),
  .status     (status),
  .out_x      (out_x),
  .out_y      (out_y),
  .out_w      (out_w),
  .out_h      (out_h),
  .rect_count (rect_count),
  .last       (last)
);
